[src/sdf_pkg.sv]
`timescale 1ns / 1ps
package sdf_pkg;

  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_APPLY_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_APPLY_SECOND = 3'd5;

  localparam logic [31:0] RST_STIFFNESS   = 32'd65536;
  localparam logic [31:0] RST_DAMPING     = 32'd0;
  localparam logic [30:0] RST_REST_LENGTH = 31'd65536;
  localparam logic [15:0] RST_TIME_STEP   = 16'd655;

  localparam int unsigned DIFF_W = IN_W + 1;
  localparam int unsigned SUM_W  = 2 * DIFF_W;
  localparam int unsigned ROOT_W = DIFF_W;
  localparam int unsigned REM_W  = ROOT_W + 3;

  typedef logic signed [DIFF_W-1:0] diff_t;

endpackage

[src/spring_damper_force_top.sv]
`timescale 1ns / 1ps
// Spring-damper force pipeline.
// Input channel (in_*): one transfer carries both anchor positions and
// velocities of one spring, packed as listed beside in_tdata.
// Result channel (out_*): one transfer per input transfer, in order, with the
// saturated force on the first body in out_tdata and the flags in out_tuser.
// Configuration channel (cfg_*): register writes, always ready; write only
// while no item is in flight.
// Throughput: one item per cycle while the result channel is not stalled.
// The pipeline is the one-bit-per-stage square root (33 stages), the one-bit-per-stage
// direction dividers (FRAC_BITS + 1 stages) and ten other register stages.
// When out_tready is low with a result waiting, the whole pipeline holds,
// in_tready drops and nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: stiffness 1.0, damping 0, rest length 1.0, time step 655, both
// apply flags set.
module spring_damper_force_top
  import sdf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // first_pos_x, first_pos_y, first_pos_z, second_pos_x, second_pos_y,
  // second_pos_z, first_vel_x, first_vel_y, first_vel_z, second_vel_x,
  // second_vel_y, second_vel_z (32 bits each)
  input  logic [12*IN_W-1:0]    in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // force_x, force_y, force_z (32 bits each)
  output logic [3*OUT_W-1:0]    out_tdata,
  // give_first, give_second, degenerate
  output logic [2:0]            out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MW   = FRAC_BITS + 1;
  localparam int DW   = FRAC_BITS + 2;
  localparam int PW   = DIFF_W + DW;
  localparam int DOTW = PW + 2;
  localparam int PMW  = DOTW - FRAC_BITS;
  localparam int PLO  = PMW / 2;
  localparam int NQ   = ROOT_W;
  localparam int NDIV = FRAC_BITS + 1;
  localparam int FW   = 64 + MW;

  logic [31:0] stiffness_r;
  logic [31:0] damping_r;
  logic [30:0] rest_length_r;
  logic [15:0] time_step_r;
  logic        apply_first_r;
  logic        apply_second_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r    <= RST_STIFFNESS;
      damping_r      <= RST_DAMPING;
      rest_length_r  <= RST_REST_LENGTH;
      time_step_r    <= RST_TIME_STEP;
      apply_first_r  <= 1'b1;
      apply_second_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STIFFNESS:    stiffness_r    <= cfg_data;
        REG_DAMPING:      damping_r      <= cfg_data;
        REG_REST_LENGTH:  rest_length_r  <= cfg_data[30:0];
        REG_TIME_STEP:    time_step_r    <= cfg_data[15:0];
        REG_APPLY_FIRST:  apply_first_r  <= cfg_data[0];
        REG_APPLY_SECOND: apply_second_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_r;
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // stage 0: differences
  logic  s0_v_r;
  diff_t s0_dp_r [3];
  diff_t s0_dv_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_dp_r[i] <= $signed({in_tdata[i*IN_W+IN_W-1], in_tdata[i*IN_W +: IN_W]})
                    - $signed({in_tdata[(3+i)*IN_W+IN_W-1], in_tdata[(3+i)*IN_W +: IN_W]});
        s0_dv_r[i] <= $signed({in_tdata[(6+i)*IN_W+IN_W-1], in_tdata[(6+i)*IN_W +: IN_W]})
                    - $signed({in_tdata[(9+i)*IN_W+IN_W-1], in_tdata[(9+i)*IN_W +: IN_W]});
      end
    end
  end

  // stage 1: squares
  logic              s1_v_r;
  logic [SUM_W-1:0]  s1_sq_r [3];
  diff_t             s1_dp_r [3];
  diff_t             s1_dv_r [3];
  logic [DIFF_W-1:0] s0_mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      s0_mag[i] = s0_dp_r[i][DIFF_W-1] ? DIFF_W'(-s0_dp_r[i]) : DIFF_W'(s0_dp_r[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= s0_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq_r[i] <= s0_mag[i] * s0_mag[i];
        s1_dp_r[i] <= s0_dp_r[i];
        s1_dv_r[i] <= s0_dv_r[i];
      end
    end
  end

  // square root, one result bit per stage
  logic              sq_v_r    [NQ+1];
  logic [SUM_W-1:0]  sq_rad_r  [NQ+1];
  logic [REM_W-1:0]  sq_rem_r  [NQ+1];
  logic [ROOT_W-1:0] sq_root_r [NQ+1];
  logic              sq_dg_r   [NQ+1];
  diff_t             sq_dp_r   [NQ+1][3];
  diff_t             sq_dv_r   [NQ+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
      sq_dg_r[0]   <= (s1_sq_r[0] | s1_sq_r[1] | s1_sq_r[2]) == '0;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        sq_dp_r[0][i] <= s1_dp_r[i];
        sq_dv_r[0][i] <= s1_dv_r[i];
      end
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_sqrt
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign rem_t = {sq_rem_r[j][REM_W-3:0], sq_rad_r[j][SUM_W-1 -: 2]};
    assign trial = {1'b0, sq_root_r[j], 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j+1] <= 1'b0;
      else if (en) sq_v_r[j+1] <= sq_v_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[j+1]  <= {sq_rad_r[j][SUM_W-3:0], 2'b00};
        sq_rem_r[j+1]  <= ge ? rem_t - trial : rem_t;
        sq_root_r[j+1] <= {sq_root_r[j][ROOT_W-2:0], ge};
        sq_dg_r[j+1]   <= sq_dg_r[j];
        for (int i = 0; i < 3; i++) begin
          sq_dp_r[j+1][i] <= sq_dp_r[j][i];
          sq_dv_r[j+1][i] <= sq_dv_r[j][i];
        end
      end
    end
  end

  // direction: three dividers, one quotient bit per stage
  logic              dq_v_r   [NDIV+1];
  logic [ROOT_W-1:0] dq_len_r [NDIV+1];
  logic [ROOT_W:0]   dq_rem_r [NDIV+1][3];
  logic [MW-1:0]     dq_q_r   [NDIV+1][3];
  logic              dq_neg_r [NDIV+1][3];
  logic              dq_lsb_r [NDIV+1][3];
  logic              dq_dg_r  [NDIV+1];
  diff_t             dq_dv_r  [NDIV+1][3];
  logic [DIFF_W-1:0] sq_mag   [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      sq_mag[i] = sq_dp_r[NQ][i][DIFF_W-1] ? DIFF_W'(-sq_dp_r[NQ][i])
                                            : DIFF_W'(sq_dp_r[NQ][i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dq_v_r[0] <= 1'b0;
    else if (en) dq_v_r[0] <= sq_v_r[NQ];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_len_r[0] <= sq_root_r[NQ];
      dq_dg_r[0]  <= sq_dg_r[NQ];
      for (int i = 0; i < 3; i++) begin
        dq_rem_r[0][i] <= {2'b00, sq_mag[i][DIFF_W-1:1]};
        dq_lsb_r[0][i] <= sq_mag[i][0];
        dq_neg_r[0][i] <= sq_dp_r[NQ][i][DIFF_W-1];
        dq_q_r[0][i]   <= '0;
        dq_dv_r[0][i]  <= sq_dv_r[NQ][i];
      end
    end
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [ROOT_W:0] t    [3];
    logic            ge   [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dq_rem_r[j][i][ROOT_W-1:0], (j == 0) ? dq_lsb_r[j][i] : 1'b0};
        ge[i] = t[i] >= {1'b0, dq_len_r[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dq_v_r[j+1] <= 1'b0;
      else if (en) dq_v_r[j+1] <= dq_v_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq_len_r[j+1] <= dq_len_r[j];
        dq_dg_r[j+1]  <= dq_dg_r[j];
        for (int i = 0; i < 3; i++) begin
          dq_rem_r[j+1][i] <= ge[i] ? t[i] - {1'b0, dq_len_r[j]} : t[i];
          dq_q_r[j+1][i]   <= {dq_q_r[j][i][MW-2:0], ge[i]};
          dq_neg_r[j+1][i] <= dq_neg_r[j][i];
          dq_lsb_r[j+1][i] <= dq_lsb_r[j][i];
          dq_dv_r[j+1][i]  <= dq_dv_r[j][i];
        end
      end
    end
  end

  logic signed [DW-1:0] dq_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      dq_d[i] = dq_neg_r[NDIV][i] ? -$signed({1'b0, dq_q_r[NDIV][i]})
                                  : $signed({1'b0, dq_q_r[NDIV][i]});
  end

  // stage A: velocity products, half-step stiffness, stretch
  logic                 a_v_r;
  logic signed [PW-1:0] a_prod_r [3];
  logic [47:0]          a_half_r;
  logic signed [ROOT_W+1:0] a_stretch_r;
  logic signed [DW-1:0] a_d_r [3];
  logic                 a_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= dq_v_r[NDIV];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_prod_r[i] <= dq_dv_r[NDIV][i] * dq_d[i];
        a_d_r[i]    <= dq_d[i];
      end
      a_half_r    <= stiffness_r * time_step_r;
      a_stretch_r <= $signed({2'b00, dq_len_r[NDIV]}) - $signed({4'b0000, rest_length_r});
      a_dg_r      <= dq_dg_r[NDIV];
    end
  end

  // stage B: projection, damping factor, stiffness partial products
  logic signed [DOTW-1:0] a_dot;
  logic [DOTW-1:0]        a_dot_mag;
  logic [ROOT_W+1:0]      a_smag;

  assign a_dot = DOTW'(a_prod_r[0]) + DOTW'(a_prod_r[1]) + DOTW'(a_prod_r[2]);
  assign a_dot_mag = a_dot[DOTW-1] ? DOTW'(-a_dot) : DOTW'(a_dot);
  assign a_smag = a_stretch_r[ROOT_W+1] ? (ROOT_W+2)'(-a_stretch_r)
                                        : (ROOT_W+2)'(a_stretch_r);

  logic                 b_v_r;
  logic [PMW-1:0]       b_pm_r;
  logic                 b_pneg_r;
  logic [32:0]          b_factor_r;
  logic [49:0]          b_t1lo_r;
  logic [48:0]          b_t1hi_r;
  logic                 b_sneg_r;
  logic signed [DW-1:0] b_d_r [3];
  logic                 b_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pm_r     <= PMW'(a_dot_mag >> FRAC_BITS);
      b_pneg_r   <= a_dot[DOTW-1];
      b_factor_r <= {1'b0, damping_r} + {2'b00, a_half_r[47:17]};
      b_t1lo_r   <= stiffness_r * a_smag[17:0];
      b_t1hi_r   <= stiffness_r * a_smag[ROOT_W+1:18];
      b_sneg_r   <= a_stretch_r[ROOT_W+1];
      b_d_r      <= a_d_r;
      b_dg_r     <= a_dg_r;
    end
  end

  // stage C: spring term, damping partial products
  logic [66:0] b_t1_full;
  assign b_t1_full = {b_t1hi_r, 18'b0} + {17'b0, b_t1lo_r};

  logic                 c_v_r;
  logic [63:0]          c_t1_r;
  logic                 c_sneg_r;
  logic [33+PLO-1:0]    c_t2lo_r;
  logic [33+PMW-PLO-1:0] c_t2hi_r;
  logic                 c_pneg_r;
  logic signed [DW-1:0] c_d_r [3];
  logic                 c_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_t1_r   <= 64'(b_t1_full >> FRAC_BITS);
      c_sneg_r <= b_sneg_r;
      c_t2lo_r <= b_factor_r * b_pm_r[PLO-1:0];
      c_t2hi_r <= b_factor_r * b_pm_r[PMW-1:PLO];
      c_pneg_r <= b_pneg_r;
      c_d_r    <= b_d_r;
      c_dg_r   <= b_dg_r;
    end
  end

  // stage D: force scalar
  logic [33+PMW-1:0]  c_t2_full;
  logic signed [63:0] c_t1s;
  logic signed [63:0] c_t2s;
  logic [63:0]        c_t2m;

  assign c_t2_full = {c_t2hi_r, PLO'(0)} + (33+PMW)'(c_t2lo_r);
  assign c_t2m = 64'(c_t2_full >> FRAC_BITS);
  assign c_t1s = c_sneg_r ? -$signed(c_t1_r) : $signed(c_t1_r);
  assign c_t2s = c_pneg_r ? -$signed(c_t2m) : $signed(c_t2m);

  logic                 d_v_r;
  logic signed [63:0]   d_c_r;
  logic signed [DW-1:0] d_d_r [3];
  logic                 d_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (en) d_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_c_r  <= -c_t1s - c_t2s;
      d_d_r  <= c_d_r;
      d_dg_r <= c_dg_r;
    end
  end

  // stage E: component partial products
  logic [63:0]   d_cm;
  logic [MW-1:0] d_dm [3];

  assign d_cm = d_c_r[63] ? 64'(-d_c_r) : 64'(d_c_r);

  always_comb begin
    for (int i = 0; i < 3; i++)
      d_dm[i] = d_d_r[i][DW-1] ? MW'(-d_d_r[i]) : MW'(d_d_r[i]);
  end

  logic             e_v_r;
  logic [32+MW-1:0] e_plo_r [3];
  logic [32+MW-1:0] e_phi_r [3];
  logic             e_neg_r [3];
  logic             e_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (en) e_v_r <= d_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_plo_r[i] <= d_cm[31:0] * d_dm[i];
        e_phi_r[i] <= d_cm[63:32] * d_dm[i];
        e_neg_r[i] <= d_c_r[63] ^ d_d_r[i][DW-1];
      end
      e_dg_r <= d_dg_r;
    end
  end

  // stage F: rescale, saturate, output register
  logic [FW-1:0] e_full [3];
  logic [FW-1:0] e_sh   [3];
  logic [31:0]   e_lim  [3];
  logic [31:0]   e_fm   [3];
  logic [31:0]   e_force [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_full[i]  = {e_phi_r[i], 32'b0} + FW'(e_plo_r[i]);
      e_sh[i]    = e_full[i] >> FRAC_BITS;
      e_lim[i]   = e_neg_r[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      e_fm[i]    = (e_sh[i] > FW'(e_lim[i])) ? e_lim[i] : e_sh[i][31:0];
      e_force[i] = e_dg_r ? 32'd0 : (e_neg_r[i] ? 32'(-e_fm[i]) : e_fm[i]);
    end
  end

  logic [3*OUT_W-1:0] out_data_r;
  logic [2:0]         out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= e_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {e_force[2], e_force[1], e_force[0]};
      out_user_r <= {e_dg_r, apply_second_r, apply_first_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[test/tb_spring_damper_force_top.sv]
`timescale 1ns / 1ps
module tb_spring_damper_force_top;
  import sdf_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 43;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [3*OUT_W-1:0] force_v;
    logic [2:0]         flags;
  } force_result_t;

  class force_scoreboard;
    logic [31:0] stiffness = RST_STIFFNESS;
    logic [31:0] damping = RST_DAMPING;
    logic [30:0] rest_length = RST_REST_LENGTH;
    logic [15:0] time_step = RST_TIME_STEP;
    logic apply_first = 1'b1;
    logic apply_second = 1'b1;
    force_result_t expected_forces[$];
    int errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_STIFFNESS: stiffness = val;
        REG_DAMPING: damping = val;
        REG_REST_LENGTH: rest_length = val[30:0];
        REG_TIME_STEP: time_step = val[15:0];
        REG_APPLY_FIRST: apply_first = val[0];
        REG_APPLY_SECOND: apply_second = val[0];
        default: ;
      endcase
    endfunction

    function longint unsigned magn(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function void note_input(logic [12*IN_W-1:0] d);
      longint dp[3], dv[3], dir[3];
      logic [127:0] sq, cand, prod;
      longint unsigned len, q, pm, half, factor, t1m, t2m, cm, lim;
      longint dot, stretch, t1, t2, c;
      logic neg;
      force_result_t r;
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        dp[i] = longint'($signed(d[32*i +: 32])) - longint'($signed(d[32*(3+i) +: 32]));
        dv[i] = longint'($signed(d[32*(6+i) +: 32])) - longint'($signed(d[32*(9+i) +: 32]));
        sq += 128'(magn(dp[i])) * 128'(magn(dp[i]));
      end
      r.force_v = '0;
      r.flags = {1'b0, apply_second, apply_first};
      if (sq == 0) begin
        r.flags[2] = 1'b1;
      end else begin
        len = 0;
        for (int b = 34; b >= 0; b--) begin
          cand = 128'(len | (64'd1 << b));
          if (cand * cand <= sq) len = cand[63:0];
        end
        dot = 0;
        for (int i = 0; i < 3; i++) begin
          q = (magn(dp[i]) << FRAC) / len;
          dir[i] = (dp[i] < 0) ? -longint'(q) : longint'(q);
          dot += dv[i] * dir[i];
        end
        pm = magn(dot) >> FRAC;
        half = (64'(stiffness) * 64'(time_step)) >> 17;
        factor = 64'(damping) + half;
        stretch = longint'(len) - longint'(64'(rest_length));
        prod = 128'(64'(stiffness)) * 128'(magn(stretch));
        t1m = prod[FRAC +: 64];
        prod = 128'(factor) * 128'(pm);
        t2m = prod[FRAC +: 64];
        t1 = (stretch < 0) ? -longint'(t1m) : longint'(t1m);
        t2 = (dot < 0) ? -longint'(t2m) : longint'(t2m);
        c = -t1 - t2;
        cm = magn(c);
        for (int i = 0; i < 3; i++) begin
          neg = (c < 0) != (dir[i] < 0);
          prod = (128'(cm) * 128'(magn(dir[i]))) >> FRAC;
          lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
          if (prod > 128'(lim)) prod = 128'(lim);
          r.force_v[32*i +: 32] = neg ? -prod[31:0] : prod[31:0];
        end
      end
      expected_forces.push_back(r);
    endfunction

    function void check(logic [3*OUT_W-1:0] data, logic [2:0] user);
      force_result_t e;
      string fname[3] = '{"force_x", "force_y", "force_z"};
      string uname[3] = '{"give_first", "give_second", "degenerate"};
      if (expected_forces.size() == 0) begin
        $error("unexpected result transfer: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      e = expected_forces.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (data[32*i +: 32] !== e.force_v[32*i +: 32]) begin
          $error("%s: expected %0d, actual %0d", fname[i],
                 $signed(e.force_v[32*i +: 32]), $signed(data[32*i +: 32]));
          errors++;
        end
        if (user[i] !== e.flags[i]) begin
          $error("%s: expected %b, actual %b", uname[i], e.flags[i], user[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [12*IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [3*OUT_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit no_idle = 0;
  bit hold_req = 0;
  int idle_cycles = 0;
  force_scoreboard sb = new();

  always #1 clk = ~clk;

  spring_damper_force_top #(.FRAC_BITS(FRAC)) i_dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_req = 0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_item(logic [12*IN_W-1:0] d);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    @(posedge clk);
    while (sb.expected_forces.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_field();
    logic [31:0] v;
    int sh;
    if ($urandom_range(0, 3) == 0) return $urandom;
    sh = $urandom_range(4, 30);
    v = $urandom & ((32'd1 << sh) - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [12*IN_W-1:0] rnd_item();
    logic [12*IN_W-1:0] d;
    for (int i = 0; i < 12; i++) d[32*i +: 32] = rnd_field();
    case ($urandom_range(0, 19))
      0: d[96 +: 96] = d[0 +: 96];
      1, 2, 3: for (int i = 0; i < 3; i++)
        d[32*(3+i) +: 32] = d[32*i +: 32] + 32'($signed($urandom_range(0, 262144)) - 131072);
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [12*IN_W-1:0] directed_item(int j);
    logic [31:0] f[12];
    logic [12*IN_W-1:0] d;
    for (int i = 0; i < 12; i++) f[i] = '0;
    case (j)
      1: for (int i = 0; i < 12; i++) f[i] = 32'h7FFF_FFFF;
      2: for (int i = 0; i < 12; i++) f[i] = 32'h8000_0000;
      3: for (int i = 0; i < 3; i++) begin
        f[i] = 32'h7FFF_FFFF; f[3+i] = 32'h8000_0000;
        f[6+i] = 32'h7FFF_FFFF; f[9+i] = 32'h8000_0000;
      end
      4: for (int i = 0; i < 3; i++) begin
        f[i] = 32'h8000_0000; f[3+i] = 32'h7FFF_FFFF;
        f[6+i] = 32'h8000_0000; f[9+i] = 32'h7FFF_FFFF;
      end
      5: f[0] = 32'd65536;
      6: f[4] = 32'd65536;
      7: f[5] = -32'd65536;
      8: begin f[0] = 32'd131072; f[6] = 32'd65536; end
      9: f[0] = 32'd1;
      10: begin f[1] = -32'd1; f[7] = 32'h7FFF_FFFF; f[10] = 32'h8000_0000; end
      11: begin f[0] = 32'h7FFF_FFFF; f[3] = 32'h8000_0000; end
      12: begin f[2] = 32'd3 << 16; f[1] = 32'd4 << 16; f[8] = -32'd5 << 16; end
      13: begin f[0] = 32'd32768; f[9] = 32'hFFFF_FFFF; end
      14: for (int i = 0; i < 12; i++) f[i] = 32'hAAAA_AAAA ^ (i[0] ? 32'hFFFF_FFFF : 32'h0);
      15: for (int i = 0; i < 12; i++) f[i] = 32'h5555_5555;
      16: begin f[3] = 32'd1; f[4] = 32'd1; f[5] = 32'd1; f[11] = 32'd1 << 20; end
      17: begin f[0] = 32'h4000_0000; f[1] = 32'h4000_0000; f[2] = 32'h4000_0000; end
      default: ;
    endcase
    for (int i = 0; i < 12; i++) d[32*i +: 32] = f[i];
    return d;
  endfunction

  task automatic write_all(logic [31:0] k, logic [31:0] damp, logic [31:0] rest,
                           logic [31:0] ts, logic a1, logic a2);
    write_reg(REG_STIFFNESS, k);
    write_reg(REG_DAMPING, damp);
    write_reg(REG_REST_LENGTH, rest);
    write_reg(REG_TIME_STEP, ts);
    write_reg(REG_APPLY_FIRST, {31'h0, a1});
    write_reg(REG_APPLY_SECOND, {31'h0, a2});
  endtask

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 && $urandom_range(0, 1) == 0) begin
        in_tvalid = 1'b0;
        @(posedge clk);
        while (sb.expected_forces.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_item(rnd_item());
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    for (int j = 0; j < 18; j++) send_item(directed_item(j));
    random_phase(100);
    drain();

    write_all(32'd1, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0);
    for (int j = 0; j < 18; j++) send_item(directed_item(j));
    random_phase(100);
    drain();

    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF, 1'b1, 1'b0);
    for (int j = 0; j < 18; j++) send_item(directed_item(j));
    random_phase(100);
    drain();

    write_all($urandom_range(1, 32'h0010_0000), $urandom_range(0, 32'h0004_0000),
              $urandom_range(1, 32'h0008_0000), $urandom_range(1, 16'hFFFF), 1'b0, 1'b1);
    hold_req = 1;
    random_phase(180);
    drain();

    write_all($urandom, $urandom, $urandom, $urandom, 1'b1, 1'b1);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    random_phase(150);
    drain();

    write_all(32'd65536, 32'd32768, 32'd65536, 32'd655, 1'b1, 1'b1);
    no_idle = 1;
    random_phase(150);
    drain();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sdf_pkg.sv
src/spring_damper_force_top.sv
test/tb_spring_damper_force_top.sv
